### hw/rtl/uvs_pkg.sv
// Shared constants, types and tables of the UV sphere vertex and index generator.
package uvs_pkg;

   localparam int CNT_W         = 9;
   localparam int MAX_SEGMENTS  = 256;
   localparam int MAX_RINGS     = 256;
   localparam int CORDIC_STAGES = 16;
   localparam int DIV_STEPS     = 41;
   localparam int ANG_W         = 32;
   localparam int CW            = 34;
   localparam int ZW            = 33;
   localparam int STG_W         = 5;
   localparam int LANES         = 4;
   localparam int IDX_W         = 17;
   localparam int RAD_W         = 16;
   localparam int POS_W         = 17;
   localparam int NRM_W         = 16;
   localparam int TEX_W         = 17;

   localparam int LANE_PHI   = 0;
   localparam int LANE_THETA = 1;
   localparam int LANE_U     = 2;
   localparam int LANE_V     = 3;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [RAD_W-1:0] RADIUS_RESET   = 16'd256;
   localparam logic [CNT_W-1:0] SEGMENTS_RESET = 9'd32;
   localparam logic [CNT_W-1:0] RINGS_RESET    = 9'd16;

   // Configuration register indexes
   localparam logic [1:0] REG_RADIUS   = 2'd0;
   localparam logic [1:0] REG_SEGMENTS = 2'd1;
   localparam logic [1:0] REG_RINGS    = 2'd2;

   // Request kinds
   localparam logic REQ_VERTEX = 1'b0;
   localparam logic REQ_QUAD   = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             quad;
      logic [CNT_W-1:0] ring;
      logic [CNT_W-1:0] seg;
   } ctl_type;

   typedef struct packed {
      logic [CNT_W-1:0]     rem;
      logic [DIV_STEPS-1:0] acc;
   } div_lane_type;

   typedef struct packed {
      ctl_type                       ctl;
      div_lane_type [LANES-1:0]      lane;
   } div_stage_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [1:0]           qdr;
   } rot_lane_type;

   typedef struct packed {
      ctl_type          ctl;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
      rot_lane_type     phi;
      rot_lane_type     theta;
   } rot_stage_type;

   typedef struct packed {
      logic                    valid;
      logic                    quad;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [NRM_W-1:0] norm_x;
      logic signed [NRM_W-1:0] norm_y;
      logic signed [NRM_W-1:0] norm_z;
      logic [TEX_W-1:0]        tex_u;
      logic [TEX_W-1:0]        tex_v;
      logic [IDX_W-1:0]        cur;
      logic [IDX_W-1:0]        nxt;
   } shade_type;

   // Arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [ANG_W-1:0] atan_turn(input logic [STG_W-1:0] idx);
      logic [ANG_W-1:0] r;
      case (idx)
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933406;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10679838;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335087;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41722;
         5'd15:   r = 32'd20861;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2608;
         5'd19:   r = 32'd1304;
         5'd20:   r = 32'd652;
         5'd21:   r = 32'd326;
         5'd22:   r = 32'd163;
         5'd23:   r = 32'd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/uvs_req_if.sv
// Request channel of the UV sphere generator.
interface uvs_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [uvs_pkg::CNT_W-1:0] ring_index;
   logic [uvs_pkg::CNT_W-1:0] seg_index;

   modport source (output valid, output req_type, output ring_index, output seg_index,
                   input ready);
   modport sink   (input valid, input req_type, input ring_index, input seg_index,
                   output ready);
endinterface

### hw/rtl/uvs_rsp_if.sv
// Result channel of the UV sphere generator.
interface uvs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [uvs_pkg::POS_W-1:0] pos_x;
   logic signed [uvs_pkg::POS_W-1:0] pos_y;
   logic signed [uvs_pkg::POS_W-1:0] pos_z;
   logic signed [uvs_pkg::NRM_W-1:0] norm_x;
   logic signed [uvs_pkg::NRM_W-1:0] norm_y;
   logic signed [uvs_pkg::NRM_W-1:0] norm_z;
   logic [uvs_pkg::TEX_W-1:0]        tex_u;
   logic [uvs_pkg::TEX_W-1:0]        tex_v;
   logic [uvs_pkg::IDX_W-1:0]        tri_a;
   logic [uvs_pkg::IDX_W-1:0]        tri_b;
   logic [uvs_pkg::IDX_W-1:0]        tri_c;
   logic                             last_of_run;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output norm_x, output norm_y, output norm_z, output tex_u, output tex_v,
                   output tri_a, output tri_b, output tri_c, output last_of_run,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input norm_x, input norm_y, input norm_z, input tex_u, input tex_v,
                   input tri_a, input tri_b, input tri_c, input last_of_run,
                   output ready);
endinterface

### hw/rtl/uvs_div_cell.sv
// One restoring-division step for the four angle and texture quotients.
module uvs_div_cell (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        adv,
   input  logic [uvs_pkg::LANES-1:0][uvs_pkg::CNT_W-1:0] divisor,
   input  uvs_pkg::div_stage_type                      stage_i,
   output uvs_pkg::div_stage_type                      stage_o
);

   uvs_pkg::div_stage_type  stage_in, stage_ff;
   logic [uvs_pkg::CNT_W:0] trial [uvs_pkg::LANES];

   // Shift in the next dividend bit, subtract the divisor where it fits
   always_comb begin
      stage_in = stage_i;
      for (int l = 0; l < uvs_pkg::LANES; l++) begin
         trial[l] = {stage_i.lane[l].rem, stage_i.lane[l].acc[uvs_pkg::DIV_STEPS-1]};
         if (trial[l] >= {1'b0, divisor[l]}) begin
            stage_in.lane[l].rem = uvs_pkg::CNT_W'(trial[l] - {1'b0, divisor[l]});
            stage_in.lane[l].acc = {stage_i.lane[l].acc[uvs_pkg::DIV_STEPS-2:0], 1'b1};
         end else begin
            stage_in.lane[l].rem = trial[l][uvs_pkg::CNT_W-1:0];
            stage_in.lane[l].acc = {stage_i.lane[l].acc[uvs_pkg::DIV_STEPS-2:0], 1'b0};
         end
      end
   end

   // Hand the step to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.ctl.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

### hw/rtl/uvs_cordic_cell.sv
// One CORDIC rotation step for the polar and azimuth angles.
module uvs_cordic_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [uvs_pkg::STG_W-1:0]     step,
   input  uvs_pkg::rot_stage_type        rot_i,
   output uvs_pkg::rot_stage_type        rot_o
);

   uvs_pkg::rot_stage_type rot_in, rot_ff;

   function automatic uvs_pkg::rot_lane_type rotate(input uvs_pkg::rot_lane_type a,
                                                    input logic [uvs_pkg::STG_W-1:0] s);
      uvs_pkg::rot_lane_type         r;
      logic signed [uvs_pkg::CW-1:0] dx;
      logic signed [uvs_pkg::CW-1:0] dy;
      logic signed [uvs_pkg::ZW-1:0] da;
      r  = a;
      dx = a.y >>> s;
      dy = a.x >>> s;
      da = $signed({1'b0, uvs_pkg::atan_turn(s)});
      if (!a.z[uvs_pkg::ZW-1]) begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - da;
      end else begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + da;
      end
      return r;
   endfunction

   // Rotate both lanes toward zero residual angle
   always_comb begin
      rot_in       = rot_i;
      rot_in.phi   = rotate(rot_i.phi, step);
      rot_in.theta = rotate(rot_i.theta, step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff.ctl.valid <= 1'b0;
      end else if (adv) begin
         rot_ff <= rot_in;
      end
   end

   assign rot_o = rot_ff;

endmodule

### hw/rtl/uvs_shade.sv
// Quadrant fix-up, trig products, normals, radius scaling and quad indices.
module uvs_shade (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic [uvs_pkg::RAD_W-1:0]       radius,
   input  logic [uvs_pkg::CNT_W-1:0]       segs,
   input  uvs_pkg::rot_stage_type          rot_i,
   output uvs_pkg::shade_type              sh_o
);

   localparam logic signed [63:0] RND30_64 = 64'sd536870912;
   localparam logic signed [50:0] RND30_51 = 51'sd536870912;
   localparam logic signed [33:0] RND16    = 34'sd32768;

   // stage 1 registers
   logic                          v1_ff, q1_ff;
   logic [uvs_pkg::TEX_W-1:0]     u1_ff, t1_ff;
   logic signed [63:0]            prx_ff, prz_ff, prx_in, prz_in;
   logic signed [31:0]            cp1_ff;
   logic [uvs_pkg::IDX_W-1:0]     cur1_ff, cur1_in;
   // stage 2 registers
   logic                          v2_ff, q2_ff;
   logic [uvs_pkg::TEX_W-1:0]     u2_ff, t2_ff;
   logic signed [33:0]            px2_ff, pz2_ff, cp2_ff, px2_in, pz2_in, cp2_in;
   logic signed [uvs_pkg::NRM_W-1:0] nx2_ff, ny2_ff, nz2_ff;
   logic [uvs_pkg::IDX_W-1:0]     cur2_ff, nxt2_ff;
   // stage 3 registers
   logic                          v3_ff, q3_ff;
   logic [uvs_pkg::TEX_W-1:0]     u3_ff, t3_ff;
   logic signed [50:0]            mx3_ff, my3_ff, mz3_ff;
   logic signed [uvs_pkg::NRM_W-1:0] nx3_ff, ny3_ff, nz3_ff;
   logic [uvs_pkg::IDX_W-1:0]     cur3_ff, nxt3_ff;

   logic signed [31:0] cp, sp, ct, st;
   logic signed [16:0] rad_s;

   function automatic logic signed [uvs_pkg::NRM_W-1:0] norm_sat(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = (v + RND16) >>> 16;
      if (t > 34'sd16384) return 16'sd16384;
      if (t < -34'sd16384) return -16'sd16384;
      return t[uvs_pkg::NRM_W-1:0];
   endfunction

   function automatic logic signed [uvs_pkg::POS_W-1:0] pos_sat(input logic signed [50:0] v);
      logic signed [50:0] t;
      t = (v + RND30_51) >>> 30;
      if (t > 51'sd65535) return 17'sd65535;
      if (t < -51'sd65535) return -17'sd65535;
      return t[uvs_pkg::POS_W-1:0];
   endfunction

   // Map the CORDIC result back to its quadrant
   always_comb begin
      case (rot_i.phi.qdr)
         2'd0:    begin cp = rot_i.phi.x[31:0];    sp = rot_i.phi.y[31:0];    end
         2'd1:    begin cp = -rot_i.phi.y[31:0];   sp = rot_i.phi.x[31:0];    end
         2'd2:    begin cp = -rot_i.phi.x[31:0];   sp = -rot_i.phi.y[31:0];   end
         default: begin cp = rot_i.phi.y[31:0];    sp = -rot_i.phi.x[31:0];   end
      endcase
      case (rot_i.theta.qdr)
         2'd0:    begin ct = rot_i.theta.x[31:0];  st = rot_i.theta.y[31:0];  end
         2'd1:    begin ct = -rot_i.theta.y[31:0]; st = rot_i.theta.x[31:0];  end
         2'd2:    begin ct = -rot_i.theta.x[31:0]; st = -rot_i.theta.y[31:0]; end
         default: begin ct = rot_i.theta.y[31:0];  st = -rot_i.theta.x[31:0]; end
      endcase
      prx_in  = sp * ct;
      prz_in  = sp * st;
      cur1_in = uvs_pkg::IDX_W'(rot_i.ctl.ring * ({1'b0, segs} + 10'd1)
                                + {10'b0, rot_i.ctl.seg});
   end

   // Round the products to Q2.30
   always_comb begin
      px2_in = 34'((prx_ff + RND30_64) >>> 30);
      pz2_in = 34'((prz_ff + RND30_64) >>> 30);
      cp2_in = 34'(cp1_ff);
   end

   assign rad_s = $signed({1'b0, radius});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= rot_i.ctl.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         q1_ff   <= rot_i.ctl.quad;
         u1_ff   <= rot_i.tex_u;
         t1_ff   <= rot_i.tex_v;
         prx_ff  <= prx_in;
         prz_ff  <= prz_in;
         cp1_ff  <= cp;
         cur1_ff <= cur1_in;

         q2_ff   <= q1_ff;
         u2_ff   <= u1_ff;
         t2_ff   <= t1_ff;
         px2_ff  <= px2_in;
         pz2_ff  <= pz2_in;
         cp2_ff  <= cp2_in;
         nx2_ff  <= norm_sat(px2_in);
         ny2_ff  <= norm_sat(cp2_in);
         nz2_ff  <= norm_sat(pz2_in);
         cur2_ff <= cur1_ff;
         nxt2_ff <= uvs_pkg::IDX_W'(cur1_ff + {8'b0, segs} + 17'd1);

         q3_ff   <= q2_ff;
         u3_ff   <= u2_ff;
         t3_ff   <= t2_ff;
         mx3_ff  <= rad_s * px2_ff;
         my3_ff  <= rad_s * cp2_ff;
         mz3_ff  <= rad_s * pz2_ff;
         nx3_ff  <= nx2_ff;
         ny3_ff  <= ny2_ff;
         nz3_ff  <= nz2_ff;
         cur3_ff <= cur2_ff;
         nxt3_ff <= nxt2_ff;
      end
   end

   // Round and saturate the scaled position
   always_comb begin
      sh_o.valid  = v3_ff;
      sh_o.quad   = q3_ff;
      sh_o.pos_x  = pos_sat(mx3_ff);
      sh_o.pos_y  = pos_sat(my3_ff);
      sh_o.pos_z  = pos_sat(mz3_ff);
      sh_o.norm_x = nx3_ff;
      sh_o.norm_y = ny3_ff;
      sh_o.norm_z = nz3_ff;
      sh_o.tex_u  = u3_ff;
      sh_o.tex_v  = t3_ff;
      sh_o.cur    = cur3_ff;
      sh_o.nxt    = nxt3_ff;
   end

endmodule

### hw/rtl/uv_sphere_vertex_index_generator_core.sv
// UV sphere tessellator: vertex attributes and quad triangle indices.
// Pipeline: 41 divider cells, 16 CORDIC cells, 3 shading stages and an output register.
// Throughput: one vertex request per cycle while the result port is not stalled; a quad
// request holds the pipe for its second triangle, as the result port moves one triangle per cycle.
// Reset: clears all valid flags and loads radius 256, 32 segments, 16 rings.
module uv_sphere_vertex_index_generator_core (
   input  logic                       clock,
   input  logic                       reset,
   uvs_req_if.sink                    req_ch,
   uvs_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [uvs_pkg::RAD_W-1:0]  csr_wdata
);

   logic [uvs_pkg::RAD_W-1:0] radius_ff;
   logic [uvs_pkg::CNT_W-1:0] segment_count_ff, ring_count_ff;
   logic [uvs_pkg::CNT_W-1:0] segs, rings, ring_c, seg_c;
   logic [uvs_pkg::LANES-1:0][uvs_pkg::CNT_W-1:0] divisor;
   logic adv, load;

   uvs_pkg::div_stage_type div_link [uvs_pkg::DIV_STEPS+1];
   uvs_pkg::rot_stage_type rot_link [uvs_pkg::CORDIC_STAGES+1];
   uvs_pkg::shade_type     sh;

   logic [uvs_pkg::ANG_W-1:0] ang_phi, ang_theta;

   logic rsp_valid_ff, pend_ff;
   logic signed [uvs_pkg::POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff, pos_x_in, pos_y_in, pos_z_in;
   logic signed [uvs_pkg::NRM_W-1:0] norm_x_ff, norm_y_ff, norm_z_ff;
   logic signed [uvs_pkg::NRM_W-1:0] norm_x_in, norm_y_in, norm_z_in;
   logic [uvs_pkg::TEX_W-1:0] tex_u_ff, tex_v_ff, tex_u_in, tex_v_in;
   logic [uvs_pkg::IDX_W-1:0] tri_a_ff, tri_b_ff, tri_c_ff, tri_a_in, tri_b_in, tri_c_in;
   logic last_ff, last_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff        <= uvs_pkg::RADIUS_RESET;
         segment_count_ff <= uvs_pkg::SEGMENTS_RESET;
         ring_count_ff    <= uvs_pkg::RINGS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            uvs_pkg::REG_RADIUS:   radius_ff        <= csr_wdata;
            uvs_pkg::REG_SEGMENTS: segment_count_ff <= csr_wdata[uvs_pkg::CNT_W-1:0];
            uvs_pkg::REG_RINGS:    ring_count_ff    <= csr_wdata[uvs_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the counts to the supported range
   always_comb begin
      if (segment_count_ff == '0) segs = uvs_pkg::CNT_W'(1);
      else if (segment_count_ff > uvs_pkg::CNT_W'(uvs_pkg::MAX_SEGMENTS))
         segs = uvs_pkg::CNT_W'(uvs_pkg::MAX_SEGMENTS);
      else segs = segment_count_ff;
      if (ring_count_ff == '0) rings = uvs_pkg::CNT_W'(1);
      else if (ring_count_ff > uvs_pkg::CNT_W'(uvs_pkg::MAX_RINGS))
         rings = uvs_pkg::CNT_W'(uvs_pkg::MAX_RINGS);
      else rings = ring_count_ff;
   end

   // Clamp the request indices and build the dividends
   always_comb begin
      ring_c = req_ch.ring_index;
      seg_c  = req_ch.seg_index;
      if (req_ch.req_type == uvs_pkg::REQ_QUAD) begin
         if (ring_c > rings - 1'b1) ring_c = rings - 1'b1;
         if (seg_c > segs - 1'b1)   seg_c  = segs - 1'b1;
      end else begin
         if (ring_c > rings) ring_c = rings;
         if (seg_c > segs)   seg_c  = segs;
      end
      div_link[0].ctl.valid = req_ch.valid;
      div_link[0].ctl.quad  = (req_ch.req_type == uvs_pkg::REQ_QUAD);
      div_link[0].ctl.ring  = ring_c;
      div_link[0].ctl.seg   = seg_c;
      for (int l = 0; l < uvs_pkg::LANES; l++) div_link[0].lane[l].rem = '0;
      div_link[0].lane[uvs_pkg::LANE_PHI].acc =
         uvs_pkg::DIV_STEPS'({ring_c, 31'b0}) + uvs_pkg::DIV_STEPS'(rings >> 1);
      div_link[0].lane[uvs_pkg::LANE_THETA].acc =
         uvs_pkg::DIV_STEPS'({seg_c, 32'b0}) + uvs_pkg::DIV_STEPS'(segs >> 1);
      div_link[0].lane[uvs_pkg::LANE_U].acc =
         uvs_pkg::DIV_STEPS'({seg_c, 16'b0}) + uvs_pkg::DIV_STEPS'(segs >> 1);
      div_link[0].lane[uvs_pkg::LANE_V].acc =
         uvs_pkg::DIV_STEPS'({ring_c, 16'b0}) + uvs_pkg::DIV_STEPS'(rings >> 1);
   end

   always_comb begin
      divisor[uvs_pkg::LANE_PHI]   = rings;
      divisor[uvs_pkg::LANE_THETA] = segs;
      divisor[uvs_pkg::LANE_U]     = segs;
      divisor[uvs_pkg::LANE_V]     = rings;
   end

   assign req_ch.ready = adv;

   // Divider chain: one quotient bit per cell
   for (genvar g = 0; g < uvs_pkg::DIV_STEPS; g++) begin : g_div
      uvs_div_cell u_div (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .divisor (divisor),
         .stage_i (div_link[g]),
         .stage_o (div_link[g+1])
      );
   end

   // Split the angles into quadrant and residual
   always_comb begin
      ang_phi   = div_link[uvs_pkg::DIV_STEPS].lane[uvs_pkg::LANE_PHI].acc[uvs_pkg::ANG_W-1:0];
      ang_theta = div_link[uvs_pkg::DIV_STEPS].lane[uvs_pkg::LANE_THETA].acc[uvs_pkg::ANG_W-1:0];
      rot_link[0].ctl       = div_link[uvs_pkg::DIV_STEPS].ctl;
      rot_link[0].tex_u     =
         div_link[uvs_pkg::DIV_STEPS].lane[uvs_pkg::LANE_U].acc[uvs_pkg::TEX_W-1:0];
      rot_link[0].tex_v     =
         div_link[uvs_pkg::DIV_STEPS].lane[uvs_pkg::LANE_V].acc[uvs_pkg::TEX_W-1:0];
      rot_link[0].phi.x     = uvs_pkg::CORDIC_GAIN;
      rot_link[0].phi.y     = '0;
      rot_link[0].phi.z     = $signed({3'b0, ang_phi[29:0]});
      rot_link[0].phi.qdr   = ang_phi[31:30];
      rot_link[0].theta.x   = uvs_pkg::CORDIC_GAIN;
      rot_link[0].theta.y   = '0;
      rot_link[0].theta.z   = $signed({3'b0, ang_theta[29:0]});
      rot_link[0].theta.qdr = ang_theta[31:30];
   end

   // CORDIC chain: one rotation per cell
   for (genvar g = 0; g < uvs_pkg::CORDIC_STAGES; g++) begin : g_rot
      uvs_cordic_cell u_rot (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .step  (uvs_pkg::STG_W'(g)),
         .rot_i (rot_link[g]),
         .rot_o (rot_link[g+1])
      );
   end

   uvs_shade u_shade (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .radius (radius_ff),
      .segs   (segs),
      .rot_i  (rot_link[uvs_pkg::CORDIC_STAGES]),
      .sh_o   (sh)
   );

   // Advance the pipe unless the tail waits on the result register
   assign load = sh.valid && (!rsp_valid_ff || rsp_ch.ready);
   assign adv  = !sh.valid || (load && (!sh.quad || pend_ff));

   // Select the result fields
   always_comb begin
      pos_x_in  = '0;
      pos_y_in  = '0;
      pos_z_in  = '0;
      norm_x_in = '0;
      norm_y_in = '0;
      norm_z_in = '0;
      tex_u_in  = '0;
      tex_v_in  = '0;
      tri_a_in  = '0;
      tri_b_in  = '0;
      tri_c_in  = '0;
      last_in   = 1'b1;
      if (!sh.quad) begin
         pos_x_in  = sh.pos_x;
         pos_y_in  = sh.pos_y;
         pos_z_in  = sh.pos_z;
         norm_x_in = sh.norm_x;
         norm_y_in = sh.norm_y;
         norm_z_in = sh.norm_z;
         tex_u_in  = sh.tex_u;
         tex_v_in  = sh.tex_v;
      end else if (!pend_ff) begin
         tri_a_in = sh.cur;
         tri_b_in = sh.nxt;
         tri_c_in = sh.cur + 1'b1;
         last_in  = 1'b0;
      end else begin
         tri_a_in = sh.cur + 1'b1;
         tri_b_in = sh.nxt;
         tri_c_in = sh.nxt + 1'b1;
      end
   end

   // Result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (load) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         if (load && sh.quad) pend_ff <= !pend_ff;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      if (load) begin
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         pos_z_ff  <= pos_z_in;
         norm_x_ff <= norm_x_in;
         norm_y_ff <= norm_y_in;
         norm_z_ff <= norm_z_in;
         tex_u_ff  <= tex_u_in;
         tex_v_ff  <= tex_v_in;
         tri_a_ff  <= tri_a_in;
         tri_b_ff  <= tri_b_in;
         tri_c_ff  <= tri_c_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pos_x       = pos_x_ff;
   assign rsp_ch.pos_y       = pos_y_ff;
   assign rsp_ch.pos_z       = pos_z_ff;
   assign rsp_ch.norm_x      = norm_x_ff;
   assign rsp_ch.norm_y      = norm_y_ff;
   assign rsp_ch.norm_z      = norm_z_ff;
   assign rsp_ch.tex_u       = tex_u_ff;
   assign rsp_ch.tex_v       = tex_v_ff;
   assign rsp_ch.tri_a       = tri_a_ff;
   assign rsp_ch.tri_b       = tri_b_ff;
   assign rsp_ch.tri_c       = tri_c_ff;
   assign rsp_ch.last_of_run = last_ff;

endmodule

### test/tb_top.sv
// Testbench for the UV sphere generator: directed table, random requests, predictor check.
`timescale 1ns / 1ps
module tb_top;

   typedef struct {
      logic signed [uvs_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
      logic signed [uvs_pkg::NRM_W-1:0] norm_x, norm_y, norm_z;
      logic [uvs_pkg::TEX_W-1:0]        tex_u, tex_v;
      logic [uvs_pkg::IDX_W-1:0]        tri_a, tri_b, tri_c;
      logic                             last_of_run;
   } vtx_result_type;

   typedef struct {
      logic                      kind;
      logic [uvs_pkg::CNT_W-1:0] ring;
      logic [uvs_pkg::CNT_W-1:0] seg;
      logic                      typed;   // expected indices typed into the row
      logic [uvs_pkg::IDX_W-1:0] a0, b0, c0;
   } stim_row_type;

   // register index with no register behind it
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [1:0] csr_index = uvs_pkg::REG_RADIUS;
   logic [uvs_pkg::RAD_W-1:0] csr_wdata = '0;

   uvs_req_if req_ch();
   uvs_rsp_if rsp_ch();

   uv_sphere_vertex_index_generator_core u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor copy of the registers
   logic [uvs_pkg::RAD_W-1:0] sph_radius = uvs_pkg::RADIUS_RESET;
   logic [uvs_pkg::CNT_W-1:0] sph_segs   = uvs_pkg::SEGMENTS_RESET;
   logic [uvs_pkg::CNT_W-1:0] sph_rings  = uvs_pkg::RINGS_RESET;

   vtx_result_type expected_results[$];
   int  error_count = 0;
   int  src_idle_pct = 0, snk_idle_pct = 0;
   bit  sink_hold = 0;
   int  quiet_cycles = 0;
   localparam int WATCHDOG = 20000;
   localparam int DRAIN    = 100;

   // fixed arctangent of 2^-i, turn units
   function automatic longint arctan_step(int i);
      longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
         20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      return t[i];
   endfunction

   function automatic longint round_q(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // rotation CORDIC over a 32-bit fraction of a turn
   function automatic void turn_sincos(logic [31:0] ang, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 652032874; y = 0; z = longint'(ang[29:0]);
      for (int i = 0; i < uvs_pkg::CORDIC_STAGES && i < 24; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_step(i);
         end else begin
            x += dx; y -= dy; z += arctan_step(i);
         end
      end
      case (ang[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint eff_count(logic [uvs_pkg::CNT_W-1:0] v, int mx);
      if (v == 0) return 1;
      if (v > mx) return mx;
      return longint'(v);
   endfunction

   // compute the expected results of one request
   task automatic predict_sphere(logic kind, logic [uvs_pkg::CNT_W-1:0] ring_in,
                                 logic [uvs_pkg::CNT_W-1:0] seg_in);
      vtx_result_type r;
      longint segs, rings, ring, seg, cp, sp, ct, st, px, pz, rad, cur, nxt;
      logic [63:0] aphi, ath;
      segs = eff_count(sph_segs, uvs_pkg::MAX_SEGMENTS);
      rings = eff_count(sph_rings, uvs_pkg::MAX_RINGS);
      ring = longint'(ring_in); seg = longint'(seg_in);
      r = '{default: '0};
      if (kind == uvs_pkg::REQ_VERTEX) begin
         if (ring > rings) ring = rings;
         if (seg > segs) seg = segs;
         aphi = ((ring << 31) + rings / 2) / rings;
         ath = ((seg << 32) + segs / 2) / segs;
         turn_sincos(aphi[31:0], cp, sp);
         turn_sincos(ath[31:0], ct, st);
         rad = longint'(sph_radius);
         px = round_q(sp * ct, 30);
         pz = round_q(sp * st, 30);
         r.pos_x = uvs_pkg::POS_W'(clip(round_q(rad * px, 30), 65535));
         r.pos_y = uvs_pkg::POS_W'(clip(round_q(rad * cp, 30), 65535));
         r.pos_z = uvs_pkg::POS_W'(clip(round_q(rad * pz, 30), 65535));
         r.norm_x = uvs_pkg::NRM_W'(clip(round_q(px, 16), 16384));
         r.norm_y = uvs_pkg::NRM_W'(clip(round_q(cp, 16), 16384));
         r.norm_z = uvs_pkg::NRM_W'(clip(round_q(pz, 16), 16384));
         r.tex_u = uvs_pkg::TEX_W'(((seg << 16) + segs / 2) / segs);
         r.tex_v = uvs_pkg::TEX_W'(((ring << 16) + rings / 2) / rings);
         r.last_of_run = 1;
         expected_results.push_back(r);
      end else begin
         if (ring > rings - 1) ring = rings - 1;
         if (seg > segs - 1) seg = segs - 1;
         cur = ring * (segs + 1) + seg;
         nxt = cur + segs + 1;
         r.tri_a = uvs_pkg::IDX_W'(cur);
         r.tri_b = uvs_pkg::IDX_W'(nxt);
         r.tri_c = uvs_pkg::IDX_W'(cur + 1);
         r.last_of_run = 0;
         expected_results.push_back(r);
         r.tri_a = uvs_pkg::IDX_W'(cur + 1);
         r.tri_b = uvs_pkg::IDX_W'(nxt);
         r.tri_c = uvs_pkg::IDX_W'(nxt + 1);
         r.last_of_run = 1;
         expected_results.push_back(r);
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // register write during idle
   task automatic write_reg(logic [1:0] idx, logic [uvs_pkg::RAD_W-1:0] val);
      @(negedge clock);
      csr_we = 1; csr_index = idx; csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      if (idx == uvs_pkg::REG_RADIUS) sph_radius = val;
      else if (idx == uvs_pkg::REG_SEGMENTS) sph_segs = val[uvs_pkg::CNT_W-1:0];
      else if (idx == uvs_pkg::REG_RINGS) sph_rings = val[uvs_pkg::CNT_W-1:0];
   endtask

   // hand over one request, honoring sender idling
   task automatic send_request(logic kind, logic [uvs_pkg::CNT_W-1:0] ring,
                               logic [uvs_pkg::CNT_W-1:0] seg);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid = 0;
         @(negedge clock);
      end
      req_ch.valid = 1; req_ch.req_type = kind;
      req_ch.ring_index = ring; req_ch.seg_index = seg;
      do @(posedge clock); while (!req_ch.ready);
      predict_sphere(kind, ring, seg);
      @(negedge clock);
      req_ch.valid = 0;
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   function automatic logic [uvs_pkg::CNT_W-1:0] rand_index(logic [uvs_pkg::CNT_W-1:0] cnt);
      int p;
      p = $urandom_range(99);
      if (p < 10) return uvs_pkg::CNT_W'($urandom_range(511));
      if (p < 20) return cnt;
      return uvs_pkg::CNT_W'($urandom_range(cnt));
   endfunction

   // receiver ready, with random stalls and forced hold-off
   always @(negedge clock) begin
      if (reset || sink_hold) rsp_ch.ready <= 0;
      else rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      vtx_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("extra result", 1, 0);
         end else begin
            e = expected_results.pop_front();
            if (rsp_ch.pos_x !== e.pos_x) report_mismatch("pos_x", rsp_ch.pos_x, e.pos_x);
            if (rsp_ch.pos_y !== e.pos_y) report_mismatch("pos_y", rsp_ch.pos_y, e.pos_y);
            if (rsp_ch.pos_z !== e.pos_z) report_mismatch("pos_z", rsp_ch.pos_z, e.pos_z);
            if (rsp_ch.norm_x !== e.norm_x) report_mismatch("norm_x", rsp_ch.norm_x, e.norm_x);
            if (rsp_ch.norm_y !== e.norm_y) report_mismatch("norm_y", rsp_ch.norm_y, e.norm_y);
            if (rsp_ch.norm_z !== e.norm_z) report_mismatch("norm_z", rsp_ch.norm_z, e.norm_z);
            if (rsp_ch.tex_u !== e.tex_u) report_mismatch("tex_u", rsp_ch.tex_u, e.tex_u);
            if (rsp_ch.tex_v !== e.tex_v) report_mismatch("tex_v", rsp_ch.tex_v, e.tex_v);
            if (rsp_ch.tri_a !== e.tri_a) report_mismatch("tri_a", rsp_ch.tri_a, e.tri_a);
            if (rsp_ch.tri_b !== e.tri_b) report_mismatch("tri_b", rsp_ch.tri_b, e.tri_b);
            if (rsp_ch.tri_c !== e.tri_c) report_mismatch("tri_c", rsp_ch.tri_c, e.tri_c);
            if (rsp_ch.last_of_run !== e.last_of_run)
               report_mismatch("last_of_run", rsp_ch.last_of_run, e.last_of_run);
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("status: fail");
         $finish;
      end
   end

   // long receiver hold-off, counted here
   task automatic hold_receiver(int cycles);
      sink_hold = 1;
      repeat (cycles) @(negedge clock);
      sink_hold = 0;
   endtask

   initial begin
      stim_row_type rows[$];
      vtx_result_type first_tri;
      logic [uvs_pkg::CNT_W-1:0] segs_cfg[5] = '{9'd1, 9'd3, 9'd256, 9'd0, 9'd300};
      logic [uvs_pkg::CNT_W-1:0] rings_cfg[5] = '{9'd256, 9'd1, 9'd7, 9'd511, 9'd0};
      logic [uvs_pkg::RAD_W-1:0] rad_cfg[5] = '{16'd0, 16'hFFFF, 16'd1000, 16'd1, 16'd256};
      req_ch.valid = 0; req_ch.req_type = uvs_pkg::REQ_VERTEX;
      req_ch.ring_index = '0; req_ch.seg_index = '0;
      rsp_ch.ready = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed rows at reset config (32 segments, 16 rings)
      rows.push_back('{uvs_pkg::REQ_VERTEX, 9'd0, 9'd0, 0, 0, 0, 0});
      rows.push_back('{uvs_pkg::REQ_VERTEX, 9'd16, 9'd32, 0, 0, 0, 0});
      rows.push_back('{uvs_pkg::REQ_VERTEX, 9'd8, 9'd8, 0, 0, 0, 0});
      rows.push_back('{uvs_pkg::REQ_VERTEX, 9'd511, 9'd511, 0, 0, 0, 0});
      rows.push_back('{uvs_pkg::REQ_VERTEX, 9'd4, 9'd24, 0, 0, 0, 0});
      rows.push_back('{uvs_pkg::REQ_QUAD, 9'd0, 9'd0, 1, 17'd0, 17'd33, 17'd1});
      rows.push_back('{uvs_pkg::REQ_QUAD, 9'd511, 9'd511, 1, 17'd526, 17'd559, 17'd527});
      rows.push_back('{uvs_pkg::REQ_QUAD, 9'd15, 9'd31, 1, 17'd526, 17'd559, 17'd527});
      rows.push_back('{uvs_pkg::REQ_QUAD, 9'd3, 9'd5, 0, 0, 0, 0});
      foreach (rows[i]) begin
         send_request(rows[i].kind, rows[i].ring, rows[i].seg);
         if (rows[i].typed) begin
            first_tri = expected_results[expected_results.size() - 2];
            if (first_tri.tri_a != rows[i].a0)
               report_mismatch("directed tri_a", first_tri.tri_a, rows[i].a0);
            if (first_tri.tri_b != rows[i].b0)
               report_mismatch("directed tri_b", first_tri.tri_b, rows[i].b0);
            if (first_tri.tri_c != rows[i].c0)
               report_mismatch("directed tri_c", first_tri.tri_c, rows[i].c0);
         end
      end
      wait_drained();

      // random phases over several settings
      for (int ph = 0; ph < 15; ph++) begin
         int mode;
         mode = ph % 3;
         src_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 52 : 0;
         snk_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 23 : 0;
         // let every request leave the pipe before touching the registers
         wait_drained();
         write_reg(uvs_pkg::REG_RADIUS, rad_cfg[ph % 5]);
         write_reg(uvs_pkg::REG_SEGMENTS, {7'd0, segs_cfg[ph % 5]});
         write_reg(uvs_pkg::REG_RINGS, {7'd0, rings_cfg[(ph + ph / 5) % 5]});
         write_reg(REG_UNUSED, 16'hFFFF);   // unused index: ignored
         fork
            if (ph == 2) hold_receiver(300);
            for (int n = 0; n < 113; n++)
               send_request(1'($urandom_range(1)), rand_index(sph_rings),
                            rand_index(sph_segs));
         join
      end
      wait_drained();
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

### files.f
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_req_if.sv
hw/rtl/uvs_rsp_if.sv
hw/rtl/uvs_div_cell.sv
hw/rtl/uvs_cordic_cell.sv
hw/rtl/uvs_shade.sv
hw/rtl/uv_sphere_vertex_index_generator_core.sv
test/tb_top.sv
